@@ src/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and round functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int WordW = 32;

	// Queue item between the front end and the compression engine.
	typedef struct packed {
		logic [WordW-1:0] word;
		logic             fin;
	} qitem_t;

	localparam int QDepth = 4;

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0c97, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[idx];
	endfunction

	// Initial hash values.
	function automatic logic [31:0] start_hash(input logic [2:0] idx);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[idx];
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ src/sha256_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message items, counts bytes and expands the last item into the
// marker, zero fill and bit length words, pushed into the word queue.
// ----------------------------------------------------------------------------
module sha256_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         in_word,
	input  logic [2:0]          in_count,
	input  logic                in_last,
	output logic                q_push,
	output sha256_pkg::qitem_t  q_data,
	input  logic                q_full
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StMark = 2'd1;
	localparam logic [1:0] StPad  = 2'd2;
	localparam logic [1:0] StLen  = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  fill_q;
	logic [60:0] bytes_q;
	logic        len_lo_q;
	logic [2:0]  cnt;
	logic [60:0] bytes_nxt;
	logic [31:0] keep;
	logic [63:0] bits;

	assign in_ready = (state_q == StIdle) && !q_full;
	assign cnt      = in_last ? ((in_count > 3'd4) ? 3'd4 : in_count) : 3'd4;
	assign bytes_nxt = bytes_q + 61'(cnt);
	assign bits     = {bytes_q, 3'b000};

	// Mask of the valid bytes of the last item.
	always_comb begin
		case (cnt)
			3'd0:    keep = 32'h0000_0000;
			3'd1:    keep = 32'hff00_0000;
			3'd2:    keep = 32'hffff_0000;
			3'd3:    keep = 32'hffff_ff00;
			default: keep = 32'hffff_ffff;
		endcase
	end

	// Word to push in each state.
	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		unique case (state_q)
			StIdle: begin
				q_push = in_valid && !q_full;
				q_data.word = (in_word & keep) | (32'h8000_0000 >> {cnt[1:0], 3'b000});
				if (!in_last || cnt == 3'd4) q_data.word = in_word;
			end
			StMark: begin
				q_push = !q_full;
				q_data.word = 32'h8000_0000;
			end
			StPad: begin
				q_push = !q_full;
			end
			StLen: begin
				q_push = !q_full;
				q_data.word = len_lo_q ? bits[31:0] : bits[63:32];
				q_data.fin  = len_lo_q;
			end
			default: ;
		endcase
	end

	// Sequencing of the padding words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			fill_q   <= '0;
			bytes_q  <= '0;
			len_lo_q <= 1'b0;
		end else if (q_push) begin
			fill_q <= fill_q + 4'd1;
			unique case (state_q)
				StIdle: begin
					bytes_q <= bytes_nxt;
					if (in_last) begin
						if (cnt == 3'd4) state_q <= StMark;
						else if (fill_q == 4'd13) state_q <= StLen;
						else state_q <= StPad;
					end
				end
				StMark: state_q <= (fill_q == 4'd13) ? StLen : StPad;
				StPad:  if (fill_q == 4'd13) state_q <= StLen;
				StLen: begin
					len_lo_q <= !len_lo_q;
					if (len_lo_q) begin
						state_q <= StIdle;
						bytes_q <= '0;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

@@ src/sha256_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Small first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module sha256_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sha256_pkg::qitem_t wdata,
	output logic               full,
	input  logic               pop,
	output sha256_pkg::qitem_t rdata,
	output logic               nempty
);

	localparam int AW = $clog2(sha256_pkg::QDepth);

	sha256_pkg::qitem_t mem_q [sha256_pkg::QDepth];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;

	assign full   = (cnt_q == (AW+1)'(sha256_pkg::QDepth));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rp_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

@@ src/sha256_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Gathers sixteen words, runs 64 rounds at one per cycle with a rolling
// message schedule, and emits the digest after the final block.
// ----------------------------------------------------------------------------
module sha256_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nempty,
	input  sha256_pkg::qitem_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_word,
	output logic [2:0]         out_index,
	output logic               out_last
);

	localparam logic [1:0] StLoad  = 2'd0;
	localparam logic [1:0] StRound = 2'd1;
	localparam logic [1:0] StAdd   = 2'd2;
	localparam logic [1:0] StOut   = 2'd3;

	logic [1:0]  state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [3:0]  fill_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  oidx_q;
	logic [31:0] s0, s1, wnew, t1, t2, big0, big1, ch, maj;

	assign q_pop     = (state_q == StLoad) && q_nempty;
	assign out_valid = (state_q == StOut);
	assign out_word  = h_q[oidx_q];
	assign out_index = oidx_q;
	assign out_last  = (oidx_q == 3'd7);

	// Round logic.
	always_comb begin
		s0 = sha256_pkg::ror(w_q[1], 7) ^ sha256_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha256_pkg::ror(w_q[14], 17) ^ sha256_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		big1 = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
			^ sha256_pkg::ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + sha256_pkg::round_k(rnd_q) + w_q[0];
		big0 = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
			^ sha256_pkg::ror(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + maj;
	end

	// Block words and working variables.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= q_data.word;
			if (fill_q == 4'd15) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (state_q == StRound) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Control and chaining values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			fill_q  <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::start_hash(3'(i));
		end else begin
			unique case (state_q)
				StLoad: if (q_pop) begin
					fill_q <= fill_q + 4'd1;
					if (fill_q == 4'd15) begin
						fin_q   <= q_data.fin;
						rnd_q   <= '0;
						state_q <= StRound;
					end
				end
				StRound: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q  <= '0;
					state_q <= fin_q ? StOut : StLoad;
				end
				StOut: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::start_hash(3'(i));
						state_q <= StLoad;
					end
				end
				default: state_q <= StLoad;
			endcase
		end
	end

endmodule

@@ src/sha256_message_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streams a message in as 32-bit words and returns its SHA-256 digest.
// ----------------------------------------------------------------------------
// Each 64-byte block takes 16 queue pops, 64 rounds and one add step; the
// single round unit sets the pace of the hasher. The front end keeps
// accepting items into a four-entry queue while the engine runs rounds,
// until the queue is full. After the last item the padding words are
// generated (one or two blocks) and eight digest items follow, indices 0
// to 7, the eighth with tlast high.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero fill
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast
);

	logic               push, full, pop, nempty;
	sha256_pkg::qitem_t wdata, rdata;
	logic [31:0]        dword;
	logic [2:0]         didx;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_word(s_tdata[31:0]), .in_count(s_tdata[34:32]), .in_last(s_tlast),
		.q_push(push), .q_data(wdata), .q_full(full)
	);

	sha256_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(wdata), .full(full),
		.pop(pop), .rdata(rdata), .nempty(nempty)
	);

	sha256_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_nempty(nempty), .q_data(rdata), .q_pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_word(dword), .out_index(didx), .out_last(m_tlast)
	);

	// Pack the result fields.
	assign m_tdata = {5'b0, didx, dword};

endmodule

@@ test/sha256_digest_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the message and digest streams, keeps its own running hash state,
// predicts the eight digest items of each message and compares them.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	output int          mismatches,
	output int          digests_pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        is_final;
	} digest_item_t;

	digest_item_t digest_q[$];
	logic [31:0]  run_hash [8];
	logic [31:0]  block_buf [16];
	int unsigned  slot;
	logic [60:0]  byte_total;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Standard starting state of a message.
	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			run_hash[i] = sha256_pkg::start_hash(i[2:0]);
		slot = 0;
		byte_total = '0;
	endtask

	// One 64-round compression of the buffered block.
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = block_buf[i];
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++)
			v[i] = run_hash[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(i[5:0]) + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			run_hash[i] += v[i];
	endtask

	task automatic append_word(input logic [31:0] word);
		block_buf[slot] = word;
		slot++;
		if (slot == 16) begin
			compress();
			slot = 0;
		end
	endtask

	// Absorb one message item; a final item pads and queues the digest.
	task automatic absorb_item(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
		int unsigned n;
		logic [31:0] keep;
		logic [63:0] bit_len;
		digest_item_t item;
		if (!fin) begin
			byte_total += 61'd4;
			append_word(data);
			return;
		end
		n = (cnt > 3'd4) ? 4 : cnt;
		byte_total += 61'(n);
		if (n == 4) begin
			append_word(data);
			append_word(32'h8000_0000);
		end else begin
			keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
			append_word((data & keep) | (32'h8000_0000 >> (8 * n)));
		end
		if (slot > 14)
			while (slot != 0)
				append_word(32'h0);
		while (slot < 14)
			append_word(32'h0);
		bit_len = {byte_total, 3'b000};
		append_word(bit_len[63:32]);
		append_word(bit_len[31:0]);
		for (int i = 0; i < 8; i++) begin
			item.word = run_hash[i];
			item.index = i[2:0];
			item.is_final = (i == 7);
			digest_q = {digest_q, item};
		end
		restart_message();
	endtask

	assign digests_pending = digest_q.size();

	// Predict on every accepted message item, compare every digest item.
	always @(posedge clk or negedge arst_n) begin
		digest_item_t exp_item;
		if (!arst_n) begin
			digest_q.delete();
			restart_message();
			mismatches <= 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_item(s_tdata[31:0], s_tdata[34:32], s_tlast);
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					if (mismatches < 10)
						$display("digest item with none expected: %h last %b", m_tdata, m_tlast);
					mismatches <= mismatches + 1;
				end else begin
					exp_item = digest_q.pop_front();
					if (m_tdata[31:0] !== exp_item.word || m_tdata[34:32] !== exp_item.index
							|| m_tdata[39:35] !== 5'd0 || m_tlast !== exp_item.is_final) begin
						if (mismatches < 10)
							$display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
								exp_item.word, exp_item.index, exp_item.is_final,
								m_tdata[31:0], m_tdata[34:32], m_tlast);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

@@ test/sha256_message_hasher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Sends directed and random messages under varying stream pressure; a checker
// beside the block predicts each digest and counts any differences.
// ----------------------------------------------------------------------------
module sha256_message_hasher_tb;

	localparam int IdleLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // data_word[31:0], byte_count[34:32], zero fill
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // digest_word[31:0], word_index[34:32], zero fill
	logic        m_tlast;
	int          mismatches;
	int          digests_pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          recv_hold;
	int          quiet_cycles;

	sha256_message_hasher dut (.*);

	sha256_digest_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver readiness, randomly idled, or held off for a long stretch.
	always @(posedge clk) begin
		if (recv_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IdleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one item and wait until it is taken, idling at random before it.
	task automatic send_item(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, cnt, data};
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// A message of body_words full words and a final item.
	task automatic send_message(input int body_words, input logic [31:0] fill,
			input logic [2:0] cnt, input bit rnd);
		for (int i = 0; i < body_words; i++)
			send_item(rnd ? $urandom() : fill, 3'($urandom_range(7)), 1'b0);
		send_item(rnd ? $urandom() : fill, cnt, 1'b1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digests_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 6;
		recv_idle_pct = 71;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, all byte counts, extreme words, padding edges.
		send_message(0, 32'h0, 3'd0, 1'b0);
		send_message(0, 32'hffff_ffff, 3'd1, 1'b0);
		send_message(0, 32'hffff_ffff, 3'd2, 1'b0);
		send_message(0, 32'h6162_63ff, 3'd3, 1'b0);
		send_message(0, 32'hffff_ffff, 3'd4, 1'b0);
		send_message(0, 32'h0, 3'd7, 1'b0);
		send_message(12, 32'hffff_ffff, 3'd4, 1'b0);
		send_message(13, 32'h0, 3'd3, 1'b0);
		drain();

		// Long receiver hold-off while the sender keeps offering items, so the
		// second message backs up behind the undelivered digest.
		recv_hold = 1'b1;
		fork
			begin
				send_message(40, 32'h0, 3'd4, 1'b1);
				send_message(20, 32'h0, 3'd2, 1'b1);
			end
			begin
				repeat (600) @(posedge clk);
				recv_hold = 1'b0;
			end
		join
		drain();

		// Random messages under three pressure settings.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 71 : 0;
			recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 6 : 0;
			for (int m = 0; m < 4; m++)
				send_message(($urandom_range(3) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 15),
					32'h0, 3'($urandom_range(7)), 1'b1);
			if (phase == 1)
				drain();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (digests_pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
